// ===== rtl/crc32re_pkg.sv =====
// ============================================================================
// crc32re_pkg
// Shared types, codes and CRC helper functions for the CRC-32 register engine.
// ============================================================================
package crc32re_pkg;

    // Input command codes as they arrive on the cmd port
    localparam logic [1:0] CMD_SEED = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_POLYNOMIAL     = 2'd0;
    localparam logic [1:0] REG_REFLECT_INPUT  = 2'd1;
    localparam logic [1:0] REG_REFLECT_OUTPUT = 2'd2;
    localparam logic [1:0] REG_FINAL_INVERT   = 2'd3;

    // Reset values
    localparam logic [31:0] POLY_DEFAULT = 32'h04C1_1DB7;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

    // Operation carried from the front end to the back end
    typedef enum logic [1:0] {
        OP_SEED,
        OP_DATA,
        OP_READ
    } op_t;

    // One classified item waiting in the queue
    typedef struct packed {
        op_t         op;
        logic [31:0] seed;
        logic [7:0]  data;
    } item_t;

    // Configuration as seen by the front and back ends
    typedef struct packed {
        logic [31:0] polynomial;
        logic        reflect_input;
        logic        reflect_output;
        logic        final_invert;
    } cfg_t;

    // Bit reversal within a byte
    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    // Bit reversal across a 32-bit word
    function automatic logic [31:0] rev32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

    // Fold one byte into the CRC, MSB first, eight shift/xor steps
    function automatic logic [31:0] fold_byte(input logic [31:0] crc,
                                              input logic [7:0]  b,
                                              input logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ poly;
            end
            else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc32_register_engine.sv =====
// ============================================================================
// crc32_register_engine
// CRC-32 engine with programmable polynomial, input/output reflection and
// final inversion, fed one command item at a time.
// ============================================================================
// Usage:
//   Input channel: drive cmd/seed_value/data_byte with push; an item is taken
//   at a clock edge where push is high and full is low. cmd 0 loads the seed,
//   1 folds one data byte, 2 (and 3) only reads.
//   Result channel: while empty is low, crc_readout holds the oldest result;
//   pop high at a clock edge takes it. Each item yields exactly one result.
//   Accepted items pass through the queue into the registered result slot.
//   Throughput: one item per cycle while full is low and results are popped,
//   set by the combinational eight-step byte fold in the back end.
//   When pop stays low, one result is held and up to QUEUE_DEPTH items wait in
//   the queue; full rises once the queue is taken up.
//   Configuration: APB writes at byte address 4*i (polynomial, reflect_input,
//   reflect_output, final_invert); write only while no item is in flight.
//   Reset: CRC register all ones, polynomial 0x04C11DB7, all three flags set,
//   queue and result slot empty.
// ============================================================================
module crc32_register_engine #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [31:0] seed_value,
    input  logic [7:0]  data_byte,
    // result channel
    output logic        empty,
    input  logic        pop,
    output logic [31:0] crc_readout,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    crc32re_pkg::cfg_t   cfg_reg;
    crc32re_pkg::item_t  fq_item;
    crc32re_pkg::item_t  qb_item;
    logic                fq_push;
    logic                q_full;
    logic                q_empty;
    logic                qb_pop;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.polynomial     <= crc32re_pkg::POLY_DEFAULT;
            cfg_reg.reflect_input  <= 1'b1;
            cfg_reg.reflect_output <= 1'b1;
            cfg_reg.final_invert   <= 1'b1;
        end
        else if (cfg_wr) begin
            unique case (reg_idx)
                crc32re_pkg::REG_POLYNOMIAL:     cfg_reg.polynomial     <= pwdata;
                crc32re_pkg::REG_REFLECT_INPUT:  cfg_reg.reflect_input  <= pwdata[0];
                crc32re_pkg::REG_REFLECT_OUTPUT: cfg_reg.reflect_output <= pwdata[0];
                crc32re_pkg::REG_FINAL_INVERT:   cfg_reg.final_invert   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            crc32re_pkg::REG_POLYNOMIAL:     prdata = cfg_reg.polynomial;
            crc32re_pkg::REG_REFLECT_INPUT:  prdata = {31'd0, cfg_reg.reflect_input};
            crc32re_pkg::REG_REFLECT_OUTPUT: prdata = {31'd0, cfg_reg.reflect_output};
            crc32re_pkg::REG_FINAL_INVERT:   prdata = {31'd0, cfg_reg.final_invert};
            default:                         prdata = '0;
        endcase
    end

    // Front end: accept and classify
    crc32re_front u_front (
        .push       (push),
        .cmd        (cmd),
        .seed_value (seed_value),
        .data_byte  (data_byte),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .full       (full),
        .q_push     (fq_push),
        .q_item     (fq_item)
    );

    // Item queue between the two sides
    crc32re_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_item (fq_item),
        .q_full  (q_full),
        .rd_en   (qb_pop),
        .q_empty (q_empty),
        .rd_item (qb_item)
    );

    // Back end: CRC update and result slot
    crc32re_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_item      (qb_item),
        .q_pop       (qb_pop),
        .empty       (empty),
        .pop         (pop),
        .crc_readout (crc_readout)
    );

endmodule

// ===== rtl/crc32re_front.sv =====
// ============================================================================
// crc32re_front
// Input side: decodes the command of each accepted item and applies input
// byte reflection, producing a classified item for the queue.
// ============================================================================
module crc32re_front (
    input  logic                 push,
    input  logic [1:0]           cmd,
    input  logic [31:0]          seed_value,
    input  logic [7:0]           data_byte,
    input  crc32re_pkg::cfg_t    cfg,
    input  logic                 q_full,
    output logic                 full,
    output logic                 q_push,
    output crc32re_pkg::item_t   q_item
);

    // Accept whenever the queue has room
    assign full   = q_full;
    assign q_push = push && !q_full;

    // Classify the command; the unused code behaves as a plain read
    always_comb
    begin
        q_item.seed = seed_value;
        q_item.data = cfg.reflect_input ? crc32re_pkg::rev8(data_byte) : data_byte;
        unique case (cmd)
            crc32re_pkg::CMD_SEED: q_item.op = crc32re_pkg::OP_SEED;
            crc32re_pkg::CMD_DATA: q_item.op = crc32re_pkg::OP_DATA;
            crc32re_pkg::CMD_READ: q_item.op = crc32re_pkg::OP_READ;
            default:               q_item.op = crc32re_pkg::OP_READ;
        endcase
    end

endmodule

// ===== rtl/crc32re_queue.sv =====
// ============================================================================
// crc32re_queue
// Short first-in first-out queue of classified items between front and back.
// ============================================================================
module crc32re_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  crc32re_pkg::item_t   wr_item,
    output logic                 q_full,
    input  logic                 rd_en,
    output logic                 q_empty,
    output crc32re_pkg::item_t   rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    crc32re_pkg::item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/crc32re_back.sv =====
// ============================================================================
// crc32re_back
// Execution side: holds the running CRC, applies seed loads and byte folds,
// and registers the formatted readout for the result port.
// ============================================================================
module crc32re_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crc32re_pkg::cfg_t    cfg,
    input  logic                 q_empty,
    input  crc32re_pkg::item_t   q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [31:0]          crc_readout
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] readout_reg, readout_next;
    logic        valid_reg, valid_next;
    logic        slot_free;
    logic [31:0] refl;

    // Take the next item when the result slot is empty or being drained
    assign slot_free   = !valid_reg || pop;
    assign q_pop       = slot_free && !q_empty;
    assign empty       = !valid_reg;
    assign crc_readout = readout_reg;

    // CRC register update
    always_comb
    begin
        crc_next = crc_reg;
        if (q_pop) begin
            unique case (q_item.op)
                crc32re_pkg::OP_SEED: crc_next = q_item.seed;
                crc32re_pkg::OP_DATA: crc_next = crc32re_pkg::fold_byte(crc_reg, q_item.data,
                                                                        cfg.polynomial);
                crc32re_pkg::OP_READ: crc_next = crc_reg;
                default:              crc_next = crc_reg;
            endcase
        end
    end

    // Readout formatting
    always_comb
    begin
        refl         = cfg.reflect_output ? crc32re_pkg::rev32(crc_next) : crc_next;
        readout_next = cfg.final_invert ? ~refl : refl;
    end

    // Result slot valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end
        else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg   <= crc32re_pkg::ALL_ONES;
            valid_reg <= 1'b0;
        end
        else begin
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            readout_reg <= readout_next;
        end
    end

endmodule

// ===== sim/tb_crc32_register_engine.sv =====
// ============================================================================
// tb_crc32_register_engine
// Self-checking testbench for the CRC-32 register engine. A directed table
// covers the standard check string, seed extremes and the unused command.
// Random message traffic follows under several polynomial and reflection
// settings, with sender gaps, receiver stalls and a long back-pressure stretch.
// ============================================================================
module tb_crc32_register_engine;

    // Unused command code, behaves as read only
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam int         DIR_ROWS   = 22;
    localparam int         NUM_PHASES = 6;

    // Clock, reset and block ports
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    logic [1:0]  cmd        = crc32re_pkg::CMD_READ;
    logic [31:0] seed_value = 32'h0;
    logic [7:0]  data_byte  = 8'h0;
    logic        empty;
    logic        pop        = 1'b0;
    logic [31:0] crc_readout;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = 4'h0;
    logic [31:0] pwdata     = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the engine state and configuration
    logic [31:0] crc_state  = crc32re_pkg::ALL_ONES;
    logic [31:0] cfg_poly   = crc32re_pkg::POLY_DEFAULT;
    logic        cfg_rin    = 1'b1;
    logic        cfg_rout   = 1'b1;
    logic        cfg_inv    = 1'b1;

    // Readouts awaited from the block, oldest first
    logic [31:0] readout_q [$];

    // Traffic shaping and bookkeeping
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;

    // Directed stimulus rows; fixed marks a hand-computed readout
    typedef struct packed {
        logic [1:0]  c;
        logic [31:0] s;
        logic [7:0]  d;
        logic        fixed;
        logic [31:0] want;
    } dir_row_t;

    dir_row_t dir_tab [DIR_ROWS];

    crc32_register_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .seed_value  (seed_value),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .crc_readout (crc_readout),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 10 unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bit mirror of a byte
    function automatic logic [7:0] mirror_byte(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h0;
        for (int i = 0; i < 8; i++)
        begin
            r = {r[6:0], v[i]};
        end
        return r;
    endfunction

    // Bit mirror of a 32-bit word
    function automatic logic [31:0] mirror_word(input logic [31:0] v);
        logic [31:0] r;
        r = 32'h0;
        for (int i = 0; i < 32; i++)
        begin
            r = {r[30:0], v[i]};
        end
        return r;
    endfunction

    // Advance the predicted CRC by one item and return its readout
    function automatic logic [31:0] crc_step(input logic [1:0]  c,
                                             input logic [31:0] s,
                                             input logic [7:0]  d);
        logic [7:0]  b;
        logic [31:0] r;
        case (c)
            crc32re_pkg::CMD_SEED:
            begin
                crc_state = s;
            end
            crc32re_pkg::CMD_DATA:
            begin
                b = cfg_rin ? mirror_byte(d) : d;
                r = crc_state ^ {b, 24'h0};
                for (int i = 0; i < 8; i++)
                begin
                    r = r[31] ? ({r[30:0], 1'b0} ^ cfg_poly) : {r[30:0], 1'b0};
                end
                crc_state = r;
            end
            default:
            begin
            end
        endcase
        r = cfg_rout ? mirror_word(crc_state) : crc_state;
        if (cfg_inv)
        begin
            r = ~r;
        end
        return r;
    endfunction

    // Offer one item; returns at the edge that accepted it
    task automatic offer_item(input logic [1:0]  c,
                              input logic [31:0] s,
                              input logic [7:0]  d,
                              input logic        fixed,
                              input logic [31:0] want);
        logic [31:0] pred;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        cmd        <= c;
        seed_value <= s;
        data_byte  <= d;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        pred = crc_step(c, s, d);
        readout_q.push_back(fixed ? want : pred);
        items_sent++;
    endtask

    // Stop sending and wait for every awaited readout, plus a short margin
    task automatic drain;
        push <= 1'b0;
        while (readout_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // APB write: setup then access, then psel and penable drop before returning
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            crc32re_pkg::REG_POLYNOMIAL:     cfg_poly = value;
            crc32re_pkg::REG_REFLECT_INPUT:  cfg_rin  = value[0];
            crc32re_pkg::REG_REFLECT_OUTPUT: cfg_rout = value[0];
            crc32re_pkg::REG_FINAL_INVERT:   cfg_inv  = value[0];
            default:
            begin
            end
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    // Full configuration; flag writes carry junk in the upper bits
    task automatic set_config(input logic [31:0] poly, input logic ri,
                              input logic ro, input logic fi);
        logic [31:0] junk;
        write_reg(crc32re_pkg::REG_POLYNOMIAL, poly);
        junk = $urandom();
        write_reg(crc32re_pkg::REG_REFLECT_INPUT, {junk[31:1], ri});
        junk = $urandom();
        write_reg(crc32re_pkg::REG_REFLECT_OUTPUT, {junk[31:1], ro});
        junk = $urandom();
        write_reg(crc32re_pkg::REG_FINAL_INVERT, {junk[31:1], fi});
    endtask

    // Mostly seeded messages closed by a read, the rest loose random items
    task automatic run_traffic(input int budget);
        int n;
        int len;
        n = 0;
        while (n < budget)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                offer_item(crc32re_pkg::CMD_SEED,
                           $urandom_range(0, 1) ? crc32re_pkg::ALL_ONES : $urandom(),
                           8'($urandom_range(0, 255)), 1'b0, 32'h0);
                len = int'($urandom_range(1, 12));
                for (int k = 0; k < len; k++)
                begin
                    offer_item(crc32re_pkg::CMD_DATA, $urandom(),
                               8'($urandom_range(0, 255)), 1'b0, 32'h0);
                end
                offer_item($urandom_range(0, 1) ? crc32re_pkg::CMD_READ : CMD_SPARE,
                           $urandom(), 8'($urandom_range(0, 255)), 1'b0, 32'h0);
                n += len + 2;
            end
            else
            begin
                offer_item(2'($urandom_range(0, 3)), $urandom(),
                           8'($urandom_range(0, 255)), 1'b0, 32'h0);
                n++;
            end
        end
    endtask

    // Result side: check each popped readout, then pick the next pop
    initial
    begin : result_side
        logic [31:0] want;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                results_seen++;
                if (readout_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected readout %h, nothing pending",
                             $time, crc_readout);
                end
                else
                begin
                    want = readout_q.pop_front();
                    if (crc_readout !== want)
                    begin
                        errors++;
                        $display("%0t: crc_readout mismatch, expected %h, got %h",
                                 $time, want, crc_readout);
                    end
                end
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // Main sequence
    initial
    begin
        // Directed rows; "123456789" under reset settings gives the check value
        dir_tab[0]  = {crc32re_pkg::CMD_READ, 32'h0000_0000, 8'h00, 1'b1, 32'h0000_0000};
        dir_tab[1]  = {CMD_SPARE,             32'hDEAD_BEEF, 8'hA5, 1'b1, 32'h0000_0000};
        dir_tab[2]  = {crc32re_pkg::CMD_SEED, 32'hFFFF_FFFF, 8'h5A, 1'b1, 32'h0000_0000};
        dir_tab[3]  = {crc32re_pkg::CMD_DATA, 32'h1234_5678, 8'h31, 1'b0, 32'h0};
        dir_tab[4]  = {crc32re_pkg::CMD_DATA, 32'h0000_0000, 8'h32, 1'b0, 32'h0};
        dir_tab[5]  = {crc32re_pkg::CMD_DATA, 32'hFFFF_FFFF, 8'h33, 1'b0, 32'h0};
        dir_tab[6]  = {crc32re_pkg::CMD_DATA, 32'h0000_0000, 8'h34, 1'b0, 32'h0};
        dir_tab[7]  = {crc32re_pkg::CMD_DATA, 32'h8765_4321, 8'h35, 1'b0, 32'h0};
        dir_tab[8]  = {crc32re_pkg::CMD_DATA, 32'h0000_0000, 8'h36, 1'b0, 32'h0};
        dir_tab[9]  = {crc32re_pkg::CMD_DATA, 32'hFFFF_FFFF, 8'h37, 1'b0, 32'h0};
        dir_tab[10] = {crc32re_pkg::CMD_DATA, 32'h0000_0000, 8'h38, 1'b0, 32'h0};
        dir_tab[11] = {crc32re_pkg::CMD_DATA, 32'h5555_5555, 8'h39, 1'b1, 32'hCBF4_3926};
        dir_tab[12] = {CMD_SPARE,             32'h0000_0000, 8'h00, 1'b1, 32'hCBF4_3926};
        dir_tab[13] = {crc32re_pkg::CMD_SEED, 32'h0000_0000, 8'hFF, 1'b1, 32'hFFFF_FFFF};
        dir_tab[14] = {crc32re_pkg::CMD_DATA, 32'hFFFF_FFFF, 8'h00, 1'b0, 32'h0};
        dir_tab[15] = {crc32re_pkg::CMD_DATA, 32'h0000_0000, 8'hFF, 1'b0, 32'h0};
        dir_tab[16] = {crc32re_pkg::CMD_SEED, 32'h0000_0001, 8'h00, 1'b1, 32'h7FFF_FFFF};
        dir_tab[17] = {crc32re_pkg::CMD_SEED, 32'h8000_0000, 8'h00, 1'b1, 32'hFFFF_FFFE};
        dir_tab[18] = {crc32re_pkg::CMD_READ, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFE};
        dir_tab[19] = {crc32re_pkg::CMD_DATA, 32'hAAAA_AAAA, 8'h80, 1'b0, 32'h0};
        dir_tab[20] = {crc32re_pkg::CMD_DATA, 32'h5555_5555, 8'h01, 1'b0, 32'h0};
        dir_tab[21] = {crc32re_pkg::CMD_SEED, 32'hFFFF_FFFF, 8'h00, 1'b1, 32'h0000_0000};

        // Reset, once
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings, no idling
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            offer_item(dir_tab[i].c, dir_tab[i].s, dir_tab[i].d,
                       dir_tab[i].fixed, dir_tab[i].want);
        end
        drain();

        // Random phases, each with a chosen setting and idle/stall pattern
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                1: set_config(32'h0000_0000, 1'b0, 1'b0, 1'b0);
                2: set_config(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
                3: set_config($urandom(), 1'b0, 1'b1, 1'b0);
                4: set_config(crc32re_pkg::POLY_DEFAULT, 1'b1, 1'b1, 1'b1);
                5: set_config($urandom(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                default:
                begin
                end
            endcase
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 62; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            run_traffic(120);
            if (p == 0)
            begin
                // long receiver hold while items keep coming
                hold_left = 60;
            end
            else if (p == 1)
            begin
                // sender pause until every readout is back
                drain();
            end
            run_traffic(135);
            drain();
        end

        $display("Covered %0d items and %0d readouts over %0d register writes,",
                 items_sent, results_seen, cfg_writes);
        $display("with seed, data and read commands under six CRC settings.");
        errors += readout_q.size();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/crc32re_pkg.sv
rtl/crc32re_front.sv
rtl/crc32re_queue.sv
rtl/crc32re_back.sv
rtl/crc32_register_engine.sv
sim/tb_crc32_register_engine.sv
